[design/tcls_pkg.sv]
package tcls_pkg;

    // result codes
    typedef enum logic [2:0] {
        TT_INT   = 3'd0,
        TT_DBL   = 3'd1,
        TT_STR   = 3'd2,
        TT_FALSE = 3'd3,
        TT_TRUE  = 3'd4
    } t_token_type;

    localparam int          TRUE_LEN  = 4;
    localparam int          FALSE_LEN = 5;
    localparam int          NUM_SPELL = 3;
    localparam logic [2:0]  POS_LIMIT = 3'd6;

    // spellings: upper case, capitalized, lower case
    localparam logic [7:0] TRUE_SPELL [NUM_SPELL][TRUE_LEN] = '{
        '{8'h54, 8'h52, 8'h55, 8'h45},
        '{8'h54, 8'h72, 8'h75, 8'h65},
        '{8'h74, 8'h72, 8'h75, 8'h65}
    };
    localparam logic [7:0] FALSE_SPELL [NUM_SPELL][FALSE_LEN] = '{
        '{8'h46, 8'h41, 8'h4C, 8'h53, 8'h45},
        '{8'h46, 8'h61, 8'h6C, 8'h73, 8'h65},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65}
    };

    // per-token scan state
    typedef struct packed {
        logic       digit_seen;
        logic [1:0] dot_count;
        logic [1:0] sign_count;
        logic       exponent_seen;
        logic       other_seen;
        logic       exponent_verdict;
        logic [2:0] char_position;
        logic [2:0] true_match;
        logic [2:0] false_match;
        logic       first_is_tf;
    } t_tok_state;

    localparam t_tok_state TOK_CLEAR = '{
        digit_seen:       1'b0,
        dot_count:        2'd0,
        sign_count:       2'd0,
        exponent_seen:    1'b0,
        other_seen:       1'b0,
        exponent_verdict: 1'b0,
        char_position:    3'd0,
        true_match:       3'b111,
        false_match:      3'b111,
        first_is_tf:      1'b0
    };

endpackage

[design/tcls_track.sv]
module tcls_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    input  logic                i_empty,
    output tcls_pkg::t_tok_state o_next
);
    import tcls_pkg::*;

    t_tok_state r_state;
    t_tok_state n_state;

    // sat-at-two increment
    function automatic logic [1:0] f_sat2(input logic [1:0] v);
        logic [1:0] res;
        res = (v >= 2'd2) ? 2'd2 : v + 2'd1;
        return res;
    endfunction

    always_comb begin
        logic [2:0] pos;
        pos = r_state.char_position;
        o_next = r_state;
        if (pos == 3'd0) begin
            o_next.first_is_tf = (i_char == 8'h54) || (i_char == 8'h46) ||
                                 (i_char == 8'h74) || (i_char == 8'h66);
        end
        priority if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_next.digit_seen = 1'b1;
        end else if (i_char == 8'h2E) begin
            o_next.dot_count = f_sat2(r_state.dot_count);
        end else if (i_char == 8'h2B || i_char == 8'h2D) begin
            o_next.sign_count = f_sat2(r_state.sign_count);
        end else if (i_char == 8'h65 || i_char == 8'h45) begin
            o_next.exponent_seen    = 1'b1;
            o_next.exponent_verdict = r_state.digit_seen & ~i_last;
        end else begin
            o_next.other_seen = 1'b1;
        end
        for (int k = 0; k < NUM_SPELL; k++) begin
            if (pos < 3'(TRUE_LEN) && TRUE_SPELL[k][pos[1:0]] != i_char) begin
                o_next.true_match[k] = 1'b0;
            end
            if (pos < 3'(FALSE_LEN) && FALSE_SPELL[k][pos] != i_char) begin
                o_next.false_match[k] = 1'b0;
            end
        end
        o_next.char_position = (pos >= POS_LIMIT - 3'd1) ? POS_LIMIT : pos + 3'd1;
    end

    // token ends on last char or empty item
    always_comb begin
        n_state = r_state;
        if (i_step) begin
            n_state = (i_empty || i_last) ? TOK_CLEAR : o_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TOK_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/tcls_decide.sv]
module tcls_decide (
    input  tcls_pkg::t_tok_state  i_state,
    input  logic                  i_empty,
    output tcls_pkg::t_token_type o_type
);
    import tcls_pkg::*;

    t_token_type w_kind;

    always_comb begin
        priority if (i_state.exponent_seen && !i_state.other_seen) begin
            w_kind = i_state.exponent_verdict ? TT_DBL : TT_STR;
        end else if (i_state.other_seen) begin
            w_kind = TT_STR;
        end else if (i_state.sign_count >= 2'd2) begin
            w_kind = TT_STR;
        end else if (i_state.dot_count >= 2'd2) begin
            w_kind = TT_STR;
        end else if (i_state.dot_count == 2'd1) begin
            w_kind = TT_DBL;
        end else begin
            w_kind = TT_INT;
        end
    end

    // empty token gives int; boolean override of short strings starting with t or f
    always_comb begin
        o_type = w_kind;
        if (i_empty) begin
            o_type = TT_INT;
        end else if (w_kind == TT_STR && i_state.char_position < POS_LIMIT &&
                     i_state.first_is_tf) begin
            if (i_state.char_position == 3'd5 && i_state.false_match != 3'b000) begin
                o_type = TT_FALSE;
            end else if ((i_state.char_position == 3'd4 ||
                          i_state.char_position == 3'd5) &&
                         i_state.true_match != 3'b000) begin
                o_type = TT_TRUE;
            end
        end
    end

endmodule

[design/token_type_classifier.sv]
// an accepted input transaction passes the input register, then the result register, to o_valid
// throughput: one character per cycle, sustained while the result side keeps up
// a character that ends a token waits for room in the output register
// reset: synchronous active-low i_rst_n clears both stage valids and the token state
// no clearing pass; the block takes a transaction in the first cycle after reset
module token_type_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_empty_token,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_token_type
);
    import tcls_pkg::*;

    // input register stage
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic        r_in_empty;

    // result register stage
    logic        r_out_valid;
    t_token_type r_out_type;

    logic        w_emits;     // staged char closes a token
    logic        w_out_free;  // result register can take a value
    logic        w_step;      // staged char is consumed this cycle
    t_tok_state  w_next;
    t_token_type w_kind;

    assign w_emits    = r_in_empty | r_in_last;
    assign w_out_free = ~r_out_valid | i_ready;
    // a char that produces no result never waits on the output side
    assign w_step     = r_in_valid & (~w_emits | w_out_free);
    assign o_ready    = ~r_in_valid | w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char  <= i_char_code;
            r_in_last  <= i_last_char;
            r_in_empty <= i_empty_token;
        end
    end

    // counters, flags and prefix masks of the token in progress
    tcls_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .i_empty (r_in_empty),
        .o_next  (w_next)
    );

    // verdict from the state including the closing char
    tcls_decide u_decide (
        .i_state (w_next),
        .i_empty (r_in_empty),
        .o_type  (w_kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emits) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emits) begin
            r_out_type <= w_kind;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_token_type = r_out_type;

endmodule

[tb/sv/token_type_checker.sv]
module token_type_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_empty_token,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_token_type,
    output int         o_mismatches,
    output int         o_pending
);
    import tcls_pkg::*;

    // spelling k of each word sits at index k: upper case, capitalized, lower case
    localparam logic [31:0] TRUE_WORDS  [3] = '{"TRUE", "True", "true"};
    localparam logic [39:0] FALSE_WORDS [3] = '{"FALSE", "False", "false"};
    localparam logic [2:0]  POS_CAP = 3'd6;

    logic       saw_digit  = 1'b0;
    logic       saw_exp    = 1'b0;
    logic       saw_other  = 1'b0;
    logic       exp_ok     = 1'b0;
    logic       starts_tf  = 1'b0;
    logic [1:0] n_dots     = 2'd0;
    logic [1:0] n_signs    = 2'd0;
    logic [2:0] pos        = 3'd0;
    logic [2:0] true_mask  = 3'b111;
    logic [2:0] false_mask = 3'b111;

    t_token_type expected_types [$];
    int          err_count = 0;

    function automatic logic [1:0] bump(input logic [1:0] n);
        return (n >= 2'd2) ? 2'd2 : n + 2'd1;
    endfunction

    function automatic void clear_scan();
        saw_digit  = 1'b0;
        saw_exp    = 1'b0;
        saw_other  = 1'b0;
        exp_ok     = 1'b0;
        starts_tf  = 1'b0;
        n_dots     = 2'd0;
        n_signs    = 2'd0;
        pos        = 3'd0;
        true_mask  = 3'b111;
        false_mask = 3'b111;
    endfunction

    // folds one character into the scan, returns 1 when the token ends
    function automatic logic scan_char(input logic [7:0] c, input logic last,
                                       input logic empty, output t_token_type kind);
        int p;
        int k;
        kind = TT_INT;
        if (empty) begin
            clear_scan();
            return 1'b1;
        end
        p = int'(pos);
        if (p == 0)
            starts_tf = (c == "T" || c == "F" || c == "t" || c == "f");

        if (c >= "0" && c <= "9") begin
            saw_digit = 1'b1;
        end else if (c == ".") begin
            n_dots = bump(n_dots);
        end else if (c == "+" || c == "-") begin
            n_signs = bump(n_signs);
        end else if (c == "e" || c == "E") begin
            saw_exp = 1'b1;
            exp_ok  = saw_digit && !last;
        end else begin
            saw_other = 1'b1;
        end

        for (k = 0; k < 3; k++) begin
            if (p < 4) begin
                if (TRUE_WORDS[k][31 - 8*p -: 8] != c)
                    true_mask[k] = 1'b0;
            end
            if (p < 5) begin
                if (FALSE_WORDS[k][39 - 8*p -: 8] != c)
                    false_mask[k] = 1'b0;
            end
        end
        pos = (p >= 5) ? POS_CAP : 3'(p + 1);

        if (!last)
            return 1'b0;

        if (saw_exp && !saw_other)
            kind = exp_ok ? TT_DBL : TT_STR;
        else if (saw_other || n_signs >= 2'd2 || n_dots >= 2'd2)
            kind = TT_STR;
        else if (n_dots == 2'd1)
            kind = TT_DBL;
        else
            kind = TT_INT;

        if (kind == TT_STR && pos < POS_CAP && starts_tf) begin
            if (pos == 3'd5 && false_mask != 3'b000)
                kind = TT_FALSE;
            else if ((pos == 3'd4 || pos == 3'd5) && true_mask != 3'b000)
                kind = TT_TRUE;
        end
        clear_scan();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_token_type want;
        t_token_type kind;
        if (!i_rst_n) begin
            clear_scan();
            expected_types.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_types.size() == 0) begin
                    $error("token_type: expected none, actual %0d", i_token_type);
                    err_count++;
                end else begin
                    want = expected_types.pop_front();
                    if (i_token_type !== want) begin
                        $error("token_type: expected %0d, actual %0d", want, i_token_type);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (scan_char(i_char_code, i_last_char, i_empty_token, kind))
                    expected_types.push_back(kind);
            end
        end
        o_mismatches <= err_count;
        o_pending    <= expected_types.size();
    end

endmodule

[tb/sv/tb_token_type_classifier.sv]
module tb_token_type_classifier;

    localparam int STIM_ITEMS = 1300;
    // no transaction on either side for this long means the block is stuck
    localparam int IDLE_LIMIT = 2000;

    localparam string SPELLINGS [6] = '{"TRUE", "True", "true", "FALSE", "False", "false"};
    localparam string TF_CHARS = "TFtf";

    typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_HOLD} t_rx_mode;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_ready       = 1'b0;
    logic [7:0] i_char_code   = 8'd0;
    logic       i_last_char   = 1'b0;
    logic       i_empty_token = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_token_type;

    int mismatches;
    int pending;
    int chars_sent   = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;

    // characters of the token being built
    logic [7:0] word [$];

    always #6 i_clk = ~i_clk;

    token_type_classifier u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .i_empty_token (i_empty_token),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_type  (o_token_type)
    );

    token_type_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .i_empty_token (i_empty_token),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_token_type  (o_token_type),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // result side: stall pattern switches at random between modes,
    // free-running mode gives stretches with no back-pressure at all
    t_rx_mode rx_mode   = RX_FREE;
    int       rx_left   = 0;
    int       hold_left = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE: i_ready <= 1'b1;
            RX_COIN: i_ready <= 1'($urandom_range(0, 1));
            RX_SLOW: i_ready <= ($urandom_range(0, 4) == 0);
            default: begin
                // long holds with i_ready low
                if (hold_left > 0) begin
                    hold_left--;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    hold_left = $urandom_range(1, 30);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // watchdog on transactions, not on elapsed time
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** token_type_classifier: FAILED **");
            $finish;
        end
    end

    // one input transaction; entered and left on a falling edge.
    // the sender works in bursts, a gap may land before any character of a token
    task automatic send_item(input logic [7:0] c, input logic last, input logic empty);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                // long run with no gaps
                burst_left = $urandom_range(50, 150);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap > 0) begin
                i_valid       <= 1'b0;
                i_char_code   <= 8'($urandom);
                i_last_char   <= 1'($urandom);
                i_empty_token <= 1'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_char_code   <= c;
        i_last_char   <= last;
        i_empty_token <= empty;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        chars_sent++;
        @(negedge i_clk);
    endtask

    // whole token from the word queue, last mark on the final character
    task automatic send_word();
        for (int i = 0; i < word.size(); i++)
            send_item(word[i], i == word.size() - 1, 1'b0);
    endtask

    task automatic send_text(input string s);
        word.delete();
        for (int i = 0; i < s.len(); i++)
            word.push_back(s[i]);
        send_word();
    endtask

    function automatic logic [7:0] any_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_sign();
        return $urandom_range(0, 1) ? "+" : "-";
    endfunction

    // numbers: half well formed, half a loose mix of number characters
    function automatic void make_numeric();
        int n;
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 2) == 0)
                word.push_back(any_sign());
            n = $urandom_range(1, 3);
            repeat (n) word.push_back(any_digit());
            if ($urandom_range(0, 1)) begin
                word.push_back(".");
                n = $urandom_range(0, 2);
                repeat (n) word.push_back(any_digit());
            end
            if ($urandom_range(0, 2) == 0) begin
                word.push_back($urandom_range(0, 1) ? "e" : "E");
                if ($urandom_range(0, 1))
                    word.push_back(any_sign());
                n = $urandom_range(0, 2);
                repeat (n) word.push_back(any_digit());
            end
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    10, 11:  word.push_back(".");
                    12, 13:  word.push_back(any_sign());
                    14, 15:  word.push_back($urandom_range(0, 1) ? "e" : "E");
                    16:      word.push_back(8'($urandom));
                    default: word.push_back(any_digit());
                endcase
            end
        end
    endfunction

    // true/false spellings, exact half the time, else bent a little
    function automatic void make_bool();
        string s;
        int    n;
        s = SPELLINGS[$urandom_range(0, 5)];
        for (int i = 0; i < s.len(); i++)
            word.push_back(s[i]);
        case ($urandom_range(0, 11))
            6: begin
                foreach (word[i])
                    if ($urandom_range(0, 1)) word[i] = word[i] ^ 8'h20;
            end
            7:  void'(word.pop_back());
            8:  word.push_back(8'($urandom));
            9:  word[$urandom_range(0, word.size() - 1)] = 8'($urandom);
            10: begin
                n = $urandom_range(1, 3);
                while (word.size() > n) void'(word.pop_back());
            end
            11: word[0] = TF_CHARS[$urandom_range(0, 3)];
            default: ;
        endcase
    endfunction

    // arbitrary bytes, sometimes opening like a boolean
    function automatic void make_bytes();
        int n;
        n = $urandom_range(1, 7);
        repeat (n) word.push_back(8'($urandom));
        if ($urandom_range(0, 2) == 0)
            word[0] = TF_CHARS[$urandom_range(0, 3)];
    endfunction

    // lengthen a boolean spelling, often past the position's saturation point
    function automatic void make_long();
        int n;
        make_bool();
        n = $urandom_range(1, 6);
        repeat (n) word.push_back(8'($urandom));
    endfunction

    initial begin
        int pick;
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty token with the other fields at their maxima,
        // each result type, exponent as the final character, too many signs
        // and dots, and the byte extremes
        send_item(8'hFF, 1'b1, 1'b1);
        send_text("9");
        send_text("0.5");
        send_text("1e5");
        send_text("e");
        send_text("true");
        send_text("FALSE");
        send_text("+-");
        send_text("..");
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);

        // random tokens
        while (chars_sent < STIM_ITEMS) begin
            word.delete();
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                make_numeric();
                send_word();
            end else if (pick < 60) begin
                make_bool();
                send_word();
            end else if (pick < 75) begin
                make_bytes();
                send_word();
            end else if (pick < 85) begin
                make_long();
                send_word();
            end else if (pick < 92) begin
                send_item(8'($urandom), 1'($urandom), 1'b1);
            end else begin
                // token cut short by an empty-token transaction
                make_bytes();
                if ($urandom_range(0, 1)) begin
                    word.delete();
                    make_bool();
                end
                n = word.size();
                for (int i = 0; i < n; i++)
                    send_item(word[i], 1'b0, 1'b0);
                send_item(8'($urandom), 1'($urandom), 1'b1);
            end
        end
        i_valid <= 1'b0;

        // drain, then wait out anything stray
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("** token_type_classifier: PASSED **");
        else
            $display("** token_type_classifier: FAILED **");
        $finish;
    end

endmodule
